// File: rtl/core/lzwr_pkg.sv
// lzwr_pkg: shared types and constants for the window/run decompressor
// no dependencies
`timescale 1ns / 1ps
package lzwr_pkg;
  localparam int WIN_DEPTH = 1024;
  localparam int WIN_AW = $clog2(WIN_DEPTH);
  localparam int LANES = 8;
  localparam int LANE_CW = $clog2(LANES + 1);
  localparam logic [26:0] PRODUCED_MAX = 27'd67108864;

  typedef enum logic [2:0] {
    PH_HEADER, PH_COMMAND, PH_OFFSET, PH_RAW, PH_RUNVAL, PH_LONGLEN, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RUN, ST_EMIT, ST_STATUS
  } seq_t;
endpackage

// File: rtl/core/lz_window_rle_decompressor.sv
// lz_window_rle_decompressor: top level, parser, history memory and packer
// depends on lzwr_pkg
`timescale 1ns / 1ps
// One compressed word is taken per input handshake. After reset the block
// sweeps its 1024-entry history memory to zero, one entry a cycle (in_ready
// low). A header or command byte that produces nothing and leaves the parser
// waiting for more is handled at acceptance alone; the last header byte and
// an empty raw copy pass through the accept, run and emit states. An input
// word that produces bytes is accepted, then each byte passes through the
// history memory (one read and one write per cycle) into the packer, and
// each full or final output word is sent from the emit state, which waits
// while a stalled receiver holds the output register. The end of a stream
// adds a status word, sent under the same condition. Window copies prime
// the registered memory read with the next source address; a copy whose
// source is the byte written in the same cycle (offset 1) is served from a
// forwarding register.
module lz_window_rle_decompressor
  import lzwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_stream_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_run_last,
  output logic        out_stream_done,
  output logic [26:0] out_total_length
);
  logic [7:0] win_mem [WIN_DEPTH];
  logic [7:0] rd_data_r;

  seq_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [WIN_AW-1:0] clr_r, clr_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [4:0]  raw_r, raw_nxt;
  logic [31:0] hsz_r, hsz_nxt;
  logic [31:0] cons_r, cons_nxt;
  logic [26:0] prod_r, prod_nxt;
  // run engine
  logic [8:0]  left_r, left_nxt;      // bytes still to produce
  logic        copy_r, copy_nxt;      // source is window
  logic [7:0]  val_r, val_nxt;        // run value
  logic [WIN_AW-1:0] src_r, src_nxt;  // copy read address
  logic        endc_r, endc_nxt;      // check end-of-stream after run
  // packer
  logic [63:0] pk_r, pk_nxt;
  logic [LANE_CW-1:0] fill_r, fill_nxt;
  // output register
  logic        ov_r, ov_nxt;
  logic [63:0] ob_r, ob_nxt;
  logic [3:0]  oc_r, oc_nxt;
  logic        ol_r, ol_nxt, od_r, od_nxt;
  logic [26:0] ot_r, ot_nxt;
  logic        wr_en;
  logic [WIN_AW-1:0] wr_addr;
  logic [7:0]  wr_data;
  logic [WIN_AW-1:0] rd_addr;
  logic [7:0]  byte_now;
  logic        out_free;
  logic        acc;
  logic [31:0] cons_inc;
  logic [9:0]  off;
  logic        done_chk;
  // parser view of the accepted word after a possible restart
  phase_t      ph_in;
  logic [31:0] cons_in, hsz_in;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (st_r == ST_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_bytes = ob_r;
  assign out_byte_count = oc_r;
  assign out_run_last = ol_r;
  assign out_stream_done = od_r;
  assign out_total_length = ot_r;

  always_ff @(posedge clk) begin
    if (wr_en) win_mem[wr_addr] <= wr_data;
    rd_data_r <= win_mem[rd_addr];
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; wp_nxt = wp_r; clr_nxt = clr_r;
    cmd_nxt = cmd_r; raw_nxt = raw_r; hsz_nxt = hsz_r; cons_nxt = cons_r;
    prod_nxt = prod_r; left_nxt = left_r; copy_nxt = copy_r; val_nxt = val_r;
    src_nxt = src_r; endc_nxt = endc_r; pk_nxt = pk_r; fill_nxt = fill_r;
    ov_nxt = ov_r && !out_ready; ob_nxt = ob_r; oc_nxt = oc_r; ol_nxt = ol_r;
    od_nxt = od_r; ot_nxt = ot_r;
    wr_en = 1'b0; wr_addr = wp_r; wr_data = 8'd0; rd_addr = src_r;
    byte_now = copy_r ? rd_data_r : val_r;
    cons_inc = 32'd0; off = 10'd0; done_chk = 1'b0;
    ph_in = ph_r; cons_in = cons_r; hsz_in = hsz_r;
    case (st_r)
      ST_CLEAR: begin
        wr_en = 1'b1; wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == WIN_AW'(WIN_DEPTH - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if (in_stream_start) begin
            ph_in = PH_HEADER; cons_in = 32'd0; hsz_in = 32'd0; prod_nxt = 27'd0;
            raw_nxt = 5'd0; cmd_nxt = 8'd0;
          end
          cons_inc = (cons_in == 32'hFFFF_FFFF) ? cons_in : cons_in + 32'd1;
          if (ph_in != PH_DONE) cons_nxt = cons_inc;
          else cons_nxt = cons_in;
          hsz_nxt = hsz_in;
          ph_nxt = ph_in;
          fill_nxt = '0; pk_nxt = 64'd0;
          copy_nxt = 1'b0; val_nxt = 8'd0; endc_nxt = 1'b1;
          case (ph_in)
            PH_HEADER: begin
              hsz_nxt = {hsz_in[23:0], in_byte};
              if (cons_inc >= 32'd4) begin
                left_nxt = 9'd0; st_nxt = ST_RUN;
              end
            end
            PH_COMMAND: begin
              cmd_nxt = in_byte;
              if (in_byte <= 8'h7F) ph_nxt = PH_OFFSET;
              else if (in_byte <= 8'h9F) begin
                raw_nxt = in_byte[4:0];
                if (in_byte[4:0] == 5'd0) begin
                  left_nxt = 9'd0; st_nxt = ST_RUN;
                end else ph_nxt = PH_RAW;
              end else if (in_byte <= 8'hDF) ph_nxt = PH_RUNVAL;
              else if (in_byte <= 8'hFE) begin
                left_nxt = {4'd0, in_byte[4:0]} + 9'd2; st_nxt = ST_RUN;
              end else ph_nxt = PH_LONGLEN;
            end
            PH_OFFSET: begin
              off = {cmd_r[1:0], in_byte};
              left_nxt = {4'd0, cmd_r[6:2]} + 9'd2;
              copy_nxt = 1'b1;
              src_nxt = wp_r - WIN_AW'(off);
              st_nxt = ST_RUN;
            end
            PH_RAW: begin
              raw_nxt = raw_r - 5'd1;
              val_nxt = in_byte; left_nxt = 9'd1;
              endc_nxt = (raw_r == 5'd1);
              st_nxt = ST_RUN;
            end
            PH_RUNVAL: begin
              val_nxt = in_byte; left_nxt = {4'd0, cmd_r[4:0]} + 9'd2;
              st_nxt = ST_RUN;
            end
            PH_LONGLEN: begin
              left_nxt = {1'b0, in_byte} + 9'd2; st_nxt = ST_RUN;
            end
            default: ;
          endcase
          // prime read for the copy
          rd_addr = src_nxt;
        end
      end
      ST_RUN: begin
        if (left_r != 9'd0) begin
          // forward when the source is the entry written last cycle
          wr_en = 1'b1; wr_data = byte_now;
          wp_nxt = wp_r + 1'b1;
          if (prod_r != PRODUCED_MAX) prod_nxt = prod_r + 27'd1;
          pk_nxt = pk_r | ({56'd0, byte_now} << {fill_r[2:0], 3'b000});
          fill_nxt = fill_r + 1'b1;
          left_nxt = left_r - 9'd1;
          src_nxt = src_r + 1'b1;
          rd_addr = src_nxt;
          // next source equals the entry being written now
          if (copy_r && src_nxt == wp_r) begin
            val_nxt = byte_now; copy_nxt = 1'b0;
          end else if (!copy_r && src_nxt != wp_r && cmd_r[7] == 1'b0
                       && ph_r == PH_OFFSET) begin
            copy_nxt = 1'b1;
          end
          if (fill_r == LANE_CW'(LANES - 1) || left_r == 9'd1) st_nxt = ST_EMIT;
        end else begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // last = no more data and no status to follow
        done_chk = (left_r == 9'd0) && endc_r && (cons_r >= hsz_r)
                   && (ph_r != PH_DONE || fill_r != '0);
        if (fill_r == '0) begin
          st_nxt = done_chk ? ST_STATUS : ST_IDLE;
          if (left_r == 9'd0 && endc_r && !done_chk) ph_nxt = PH_COMMAND;
        end else if (out_free) begin
          ov_nxt = 1'b1; ob_nxt = pk_r; oc_nxt = 4'(fill_r);
          ol_nxt = (left_r == 9'd0) && !done_chk; od_nxt = 1'b0;
          ot_nxt = prod_r;
          pk_nxt = 64'd0; fill_nxt = '0;
          if (left_r != 9'd0) begin
            st_nxt = ST_RUN; rd_addr = src_r;
          end else begin
            st_nxt = done_chk ? ST_STATUS : ST_IDLE;
            if (endc_r && !done_chk && ph_r != PH_DONE) ph_nxt = PH_COMMAND;
          end
        end else begin
          rd_addr = src_r;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          ov_nxt = 1'b1; ob_nxt = 64'd0; oc_nxt = 4'd0; ol_nxt = 1'b1;
          od_nxt = 1'b1; ot_nxt = prod_r; ph_nxt = PH_DONE; st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; ph_r <= PH_HEADER; wp_r <= '0; clr_r <= '0;
      cmd_r <= 8'd0; raw_r <= 5'd0; hsz_r <= 32'd0; cons_r <= 32'd0;
      prod_r <= 27'd0; left_r <= 9'd0; fill_r <= '0; ov_r <= 1'b0;
      copy_r <= 1'b0; endc_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; wp_r <= wp_nxt; clr_r <= clr_nxt;
      cmd_r <= cmd_nxt; raw_r <= raw_nxt; hsz_r <= hsz_nxt; cons_r <= cons_nxt;
      prod_r <= prod_nxt; left_r <= left_nxt; fill_r <= fill_nxt;
      ov_r <= ov_nxt; copy_r <= copy_nxt; endc_r <= endc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt; src_r <= src_nxt; pk_r <= pk_nxt;
    ob_r <= ob_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt; od_r <= od_nxt;
    ot_r <= ot_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(ob_r))
    else $error("output word dropped while stalled");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LANE_CW'(LANES))
    else $error("packer overfilled");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && od_r |-> oc_r == 4'd0 && ol_r)
    else $error("status word carries data");
endmodule
